// ----- design/cpu6502_pkg.sv -----
// shared types and constants for the 6502 subset core
// no dependencies
package cpu6502_pkg;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_FETCH, ST_OPND_LO, ST_OPND_HI, ST_PTR_LO, ST_PTR_HI,
    ST_DATA, ST_EXEC, ST_RDWAIT, ST_DONE
  } state_t;

  typedef enum logic [4:0] {
    K_ORA, K_AND, K_EOR, K_ADC, K_STA, K_LDA, K_CMP, K_SBC,
    K_LDX, K_LDY, K_STX, K_STY, K_CPX, K_CPY, K_BIT,
    K_TAX, K_TAY, K_TXA, K_TYA, K_TSX, K_TXS,
    K_PHA, K_PHP, K_PLA, K_PLP, K_NONE
  } kind_t;

  typedef enum logic [3:0] {
    AM_IMP, AM_IMM, AM_ZP, AM_ZPX, AM_ZPY, AM_ABS, AM_ABX, AM_ABY, AM_INX, AM_INY
  } amode_t;

  localparam logic [1:0] ACT_EXEC  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [7:0] FL_C = 8'h01;
  localparam logic [7:0] FL_Z = 8'h02;
  localparam logic [7:0] FL_B = 8'h10;
  localparam logic [7:0] FL_R = 8'h20;
  localparam logic [7:0] FL_V = 8'h40;
  localparam logic [7:0] FL_N = 8'h80;

  typedef struct packed {
    kind_t      kind;
    amode_t     mode;
    logic [2:0] cyc;
  } dec_t;

  function automatic dec_t decode(input logic [7:0] opc);
    dec_t d;
    logic [2:0] grp;
    logic [2:0] sel;
    d.kind = K_NONE;
    d.mode = AM_IMP;
    d.cyc  = 3'd2;
    grp = opc[7:5];
    sel = opc[4:2];
    if (opc[1:0] == 2'b01) begin
      case (sel)
        3'd0: begin d.mode = AM_INX; d.cyc = 3'd6; end
        3'd1: begin d.mode = AM_ZP;  d.cyc = 3'd3; end
        3'd2: begin d.mode = AM_IMM; d.cyc = 3'd2; end
        3'd3: begin d.mode = AM_ABS; d.cyc = 3'd4; end
        3'd4: begin d.mode = AM_INY; d.cyc = 3'd5; end
        3'd5: begin d.mode = AM_ZPX; d.cyc = 3'd4; end
        3'd6: begin d.mode = AM_ABY; d.cyc = 3'd4; end
        default: begin d.mode = AM_ABX; d.cyc = 3'd4; end
      endcase
      d.kind = kind_t'({2'b00, grp});
      if (grp == 3'd4) begin
        if (sel == 3'd2) d.kind = K_NONE;
        if (sel == 3'd4) d.cyc = 3'd6;
        if (sel == 3'd6 || sel == 3'd7) d.cyc = 3'd5;
      end
    end else begin
      case (opc)
        8'ha2: begin d.kind = K_LDX; d.mode = AM_IMM; d.cyc = 3'd2; end
        8'ha6: begin d.kind = K_LDX; d.mode = AM_ZP;  d.cyc = 3'd3; end
        8'hb6: begin d.kind = K_LDX; d.mode = AM_ZPY; d.cyc = 3'd4; end
        8'hae: begin d.kind = K_LDX; d.mode = AM_ABS; d.cyc = 3'd4; end
        8'hbe: begin d.kind = K_LDX; d.mode = AM_ABY; d.cyc = 3'd4; end
        8'ha0: begin d.kind = K_LDY; d.mode = AM_IMM; d.cyc = 3'd2; end
        8'ha4: begin d.kind = K_LDY; d.mode = AM_ZP;  d.cyc = 3'd3; end
        8'hb4: begin d.kind = K_LDY; d.mode = AM_ZPX; d.cyc = 3'd4; end
        8'hac: begin d.kind = K_LDY; d.mode = AM_ABS; d.cyc = 3'd4; end
        8'hbc: begin d.kind = K_LDY; d.mode = AM_ABX; d.cyc = 3'd4; end
        8'h86: begin d.kind = K_STX; d.mode = AM_ZP;  d.cyc = 3'd3; end
        8'h96: begin d.kind = K_STX; d.mode = AM_ZPY; d.cyc = 3'd4; end
        8'h8e: begin d.kind = K_STX; d.mode = AM_ABS; d.cyc = 3'd4; end
        8'h84: begin d.kind = K_STY; d.mode = AM_ZP;  d.cyc = 3'd3; end
        8'h94: begin d.kind = K_STY; d.mode = AM_ZPX; d.cyc = 3'd4; end
        8'h8c: begin d.kind = K_STY; d.mode = AM_ABS; d.cyc = 3'd4; end
        8'he0: begin d.kind = K_CPX; d.mode = AM_IMM; d.cyc = 3'd2; end
        8'he4: begin d.kind = K_CPX; d.mode = AM_ZP;  d.cyc = 3'd3; end
        8'hec: begin d.kind = K_CPX; d.mode = AM_ABS; d.cyc = 3'd4; end
        8'hc0: begin d.kind = K_CPY; d.mode = AM_IMM; d.cyc = 3'd2; end
        8'hc4: begin d.kind = K_CPY; d.mode = AM_ZP;  d.cyc = 3'd3; end
        8'hcc: begin d.kind = K_CPY; d.mode = AM_ABS; d.cyc = 3'd4; end
        8'h24: begin d.kind = K_BIT; d.mode = AM_ZP;  d.cyc = 3'd3; end
        8'h2c: begin d.kind = K_BIT; d.mode = AM_ABS; d.cyc = 3'd4; end
        8'haa: d.kind = K_TAX;
        8'ha8: d.kind = K_TAY;
        8'h8a: d.kind = K_TXA;
        8'h98: d.kind = K_TYA;
        8'hba: d.kind = K_TSX;
        8'h9a: d.kind = K_TXS;
        8'h48: begin d.kind = K_PHA; d.cyc = 3'd3; end
        8'h08: begin d.kind = K_PHP; d.cyc = 3'd3; end
        8'h68: begin d.kind = K_PLA; d.cyc = 3'd4; end
        8'h28: begin d.kind = K_PLP; d.cyc = 3'd4; end
        default: d.kind = K_NONE;
      endcase
    end
    return d;
  endfunction

endpackage

// ----- design/cpu6502_core_subset_top.sv -----
// 6502 subset core with internal memory, stream in and stream out
// depends on cpu6502_pkg
// An accepted write or unused word goes straight to the result, a read waits for the memory
// read, an instruction fetches its opcode and the operand, pointer and data bytes its mode needs,
// then executes, and an unhandled opcode ends after decode; one memory access per cycle through
// the single port. Next word accepted the cycle after the result is taken. Reset: synchronous;
// memory cleared one byte per cycle with s_tready low; registers zero, status 0x20.
module cpu6502_core_subset_top #(
  parameter int MEM_SIZE = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // action[1:0], mem_address[17:2], write_byte[25:18], zero fill to 32
  input  logic [31:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // accumulator, index_x, index_y, status_flags, stack_pointer, program_counter,
  // read_byte, cycles_used, bad_opcode from bit 0 up; zero fill to 72
  output logic [71:0] m_tdata
);
  import cpu6502_pkg::*;

  localparam int AW = $clog2(MEM_SIZE);

  state_t state, state_next;

  logic [7:0] mem [MEM_SIZE];
  logic [7:0] rdata;
  logic [AW-1:0] clr;

  logic [7:0]  a, x, y, p, sp;
  logic [15:0] pc;
  logic [7:0]  opc, lo, hi, ptr, m;
  dec_t        dec;
  logic [7:0]  rb;
  logic [2:0]  cyc;
  logic        bad;

  // memory port controls
  logic [15:0] maddr;
  logic        mwe;
  logic [7:0]  mwdata;
  logic        inrange;

  logic [15:0] ea;
  logic [7:0]  ea_hi;

  // opcode is decoded straight from the read port in the cycle it arrives
  assign dec = decode((state == ST_OPND_LO) ? rdata : opc);
  assign inrange = ({1'b0, maddr} < 17'(MEM_SIZE));
  // data byte for the exec cycle comes straight from the read port
  assign m = rdata;
  // high address byte arrives on the read port in the data cycle
  assign ea_hi = (state == ST_DATA) ? rdata : hi;

  // effective address from collected operand bytes
  always_comb begin
    case (dec.mode)
      AM_IMM: ea = pc + 16'd1;
      AM_ZP:  ea = {8'h00, lo};
      AM_ZPX: ea = {8'h00, lo + x};
      AM_ZPY: ea = {8'h00, lo + y};
      AM_ABS: ea = {ea_hi, lo};
      AM_ABX: ea = {ea_hi, lo} + {8'h00, x};
      AM_ABY: ea = {ea_hi, lo} + {8'h00, y};
      AM_INX: ea = {ea_hi, ptr};
      AM_INY: ea = {ea_hi, ptr} + {8'h00, y};
      default: ea = 16'h0000;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (32'(clr) == MEM_SIZE - 1) state_next = ST_IDLE;
      ST_IDLE: if (s_tvalid) begin
        if (s_tdata[1:0] == ACT_EXEC) state_next = ST_FETCH;
        else if (s_tdata[1:0] == ACT_READ) state_next = ST_RDWAIT;
        else state_next = ST_DONE;
      end
      ST_FETCH: state_next = ST_OPND_LO;
      ST_OPND_LO: begin
        if (dec.kind == K_NONE) state_next = ST_DONE;
        else if (dec.mode == AM_IMP) begin
          if (dec.kind == K_PLA || dec.kind == K_PLP) state_next = ST_DATA;
          else state_next = ST_EXEC;
        end else state_next = ST_OPND_HI;
      end
      ST_OPND_HI: begin
        if (dec.mode == AM_INX || dec.mode == AM_INY) state_next = ST_PTR_LO;
        else state_next = ST_DATA;
      end
      ST_PTR_LO: state_next = ST_PTR_HI;
      ST_PTR_HI: state_next = ST_DATA;
      ST_DATA: state_next = ST_EXEC;
      ST_EXEC: state_next = ST_DONE;
      ST_RDWAIT: state_next = ST_DONE;
      ST_DONE: if (m_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // memory address and write strobe per state
  always_comb begin
    maddr  = 16'h0000;
    mwe    = 1'b0;
    mwdata = 8'h00;
    case (state)
      ST_CLEAR: begin
        maddr = 16'(clr);
        mwe   = 1'b1;
      end
      ST_IDLE: begin
        maddr  = s_tdata[17:2];
        mwe    = s_tvalid && (s_tdata[1:0] == ACT_WRITE);
        mwdata = s_tdata[25:18];
      end
      ST_FETCH: maddr = pc;
      ST_OPND_LO: maddr = pc + 16'd1;
      ST_OPND_HI: maddr = pc + 16'd2;
      ST_PTR_LO: maddr = (dec.mode == AM_INX) ? {8'h00, lo + x} : {8'h00, lo};
      ST_PTR_HI: maddr = (dec.mode == AM_INX) ? {8'h00, lo + x + 8'd1}
                                             : {8'h00, lo + 8'd1};
      ST_DATA: begin
        if (dec.kind == K_PLA || dec.kind == K_PLP) maddr = {8'h01, sp + 8'd1};
        else maddr = ea;
      end
      ST_EXEC: begin
        case (dec.kind)
          K_STA: begin maddr = ea; mwe = 1'b1; mwdata = a; end
          K_STX: begin maddr = ea; mwe = 1'b1; mwdata = x; end
          K_STY: begin maddr = ea; mwe = 1'b1; mwdata = y; end
          K_PHA: begin maddr = {8'h01, sp}; mwe = 1'b1; mwdata = a; end
          K_PHP: begin maddr = {8'h01, sp}; mwe = 1'b1; mwdata = p | FL_B | FL_R; end
          default: mwe = 1'b0;
        endcase
      end
      default: maddr = 16'h0000;
    endcase
  end

  // single port memory, registered read
  always_ff @(posedge clk) begin
    if (mwe && inrange) mem[maddr[AW-1:0]] <= mwdata;
    rdata <= inrange ? mem[maddr[AW-1:0]] : 8'h00;
  end

  // shared alu: one result per instruction in the exec cycle
  logic [7:0] alu_res, p_new, a_new, x_new, y_new, sp_new;
  logic [8:0] sum;
  logic [7:0] opb, cmp_r;
  always_comb begin
    a_new = a; x_new = x; y_new = y; sp_new = sp; p_new = p;
    alu_res = 8'h00;
    opb = (dec.kind == K_SBC) ? ~m : m;
    cmp_r = (dec.kind == K_CPX) ? x : (dec.kind == K_CPY) ? y : a;
    if (dec.kind == K_CMP || dec.kind == K_CPX || dec.kind == K_CPY)
      sum = {1'b0, cmp_r} + {1'b0, ~m} + 9'd1;
    else
      sum = {1'b0, a} + {1'b0, opb} + {8'h00, p[0]};
    case (dec.kind)
      K_ORA: begin a_new = a | m; alu_res = a_new; end
      K_AND: begin a_new = a & m; alu_res = a_new; end
      K_EOR: begin a_new = a ^ m; alu_res = a_new; end
      K_ADC, K_SBC: begin
        a_new = sum[7:0]; alu_res = a_new;
        p_new[0] = sum[8];
        p_new[6] = ~(a[7] ^ opb[7]) & (a[7] ^ sum[7]);
      end
      K_LDA: begin a_new = m; alu_res = m; end
      K_LDX: begin x_new = m; alu_res = m; end
      K_LDY: begin y_new = m; alu_res = m; end
      K_CMP, K_CPX, K_CPY: begin alu_res = sum[7:0]; p_new[0] = sum[8]; end
      K_TAX: begin x_new = a; alu_res = a; end
      K_TAY: begin y_new = a; alu_res = a; end
      K_TXA: begin a_new = x; alu_res = x; end
      K_TYA: begin a_new = y; alu_res = y; end
      K_TSX: begin x_new = sp; alu_res = sp; end
      K_TXS: sp_new = x;
      K_PHA, K_PHP: sp_new = sp - 8'd1;
      K_PLA: begin sp_new = sp + 8'd1; a_new = m; alu_res = m; end
      K_PLP: begin sp_new = sp + 8'd1; p_new = (m & ~FL_B) | FL_R; end
      default: alu_res = 8'h00;
    endcase
    case (dec.kind)
      K_BIT: begin
        p_new[7] = m[7]; p_new[6] = m[6]; p_new[1] = ((a & m) == 8'h00);
      end
      K_STA, K_STX, K_STY, K_TXS, K_PHA, K_PHP, K_PLP: p_new[7] = p_new[7];
      default: begin
        p_new[7] = alu_res[7]; p_new[1] = (alu_res == 8'h00);
      end
    endcase
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr <= '0;
      a <= 8'h00; x <= 8'h00; y <= 8'h00; p <= FL_R; sp <= 8'h00; pc <= 16'h0000;
      rb <= 8'h00; cyc <= 3'd0; bad <= 1'b0;
      opc <= 8'h00; lo <= 8'h00; hi <= 8'h00; ptr <= 8'h00;
    end else begin
      state <= state_next;
      case (state)
        ST_CLEAR: clr <= clr + AW'(1);
        ST_IDLE: if (s_tvalid) begin
          rb <= 8'h00; cyc <= 3'd0; bad <= 1'b0;
        end
        ST_OPND_LO: begin
          opc <= rdata;
          if (dec.kind == K_NONE) bad <= 1'b1;
        end
        ST_OPND_HI: lo <= rdata;
        ST_PTR_HI: ptr <= rdata;
        ST_DATA: begin
          if (dec.mode == AM_ABS || dec.mode == AM_ABX || dec.mode == AM_ABY)
            hi <= rdata;
          else if (dec.mode == AM_INX || dec.mode == AM_INY) hi <= rdata;
        end
        ST_EXEC: begin
          a <= a_new; x <= x_new; y <= y_new; sp <= sp_new; p <= p_new | FL_R;
          cyc <= dec.cyc;
          case (dec.mode)
            AM_IMP: pc <= pc + 16'd1;
            AM_ABS, AM_ABX, AM_ABY: pc <= pc + 16'd3;
            default: pc <= pc + 16'd2;
          endcase
        end
        ST_RDWAIT: rb <= rdata;
        default: ;
      endcase
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_DONE);
  assign m_tdata = {4'h0, bad, cyc, rb, pc, sp, p | FL_R, y, x, a};

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for the 6502 subset core: directed table, then random programs
// depends on cpu6502_pkg and cpu6502_core_subset_top
`timescale 1ns / 1ps
module tb_top;
  import cpu6502_pkg::*;

  localparam int N_ITEMS   = 1300;
  localparam int MAX_GAP   = 13;
  localparam int CYC_LIMIT = 2000000;

  typedef struct {
    logic [7:0]  acc;
    logic [7:0]  xr;
    logic [7:0]  yr;
    logic [7:0]  flags;
    logic [7:0]  sp;
    logic [15:0] pc;
    logic [7:0]  rd;
    logic [2:0]  cyc;
    logic        bad;
  } cpu_view_t;

  // directed row; pc/rd/cyc/bad are typed in only where chk is set
  typedef struct {
    logic [1:0]  act;
    logic [15:0] addr;
    logic [7:0]  wb;
    bit          chk;
    logic [15:0] pc;
    logic [7:0]  rd;
    logic [2:0]  cyc;
    logic        bad;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;

  cpu6502_core_subset_top i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow machine state
  logic [7:0]  mem [0:65535];
  logic [7:0]  r_a, r_x, r_y, r_p, r_s;
  logic [15:0] r_pc;

  cpu_view_t   pending_q [$];
  logic [7:0]  legal_ops [$];
  int          n_err = 0;
  int          n_sent = 0;
  int          n_got = 0;
  int          n_exec = 0;
  int          n_bad = 0;
  int          cycle_cnt = 0;
  bit          snd_fast = 0;
  bit          rcv_fast = 0;

  // opcode decode written from the published opcode table
  function automatic void op_info(input logic [7:0] op, output kind_t k, output amode_t m,
                                  output logic [2:0] c);
    m = AM_IMP;
    c = 3'd2;
    k = K_NONE;
    if (op[1:0] == 2'b01) begin
      case (op[4:2])
        3'd0: begin m = AM_INX; c = 3'd6; end
        3'd1: begin m = AM_ZP;  c = 3'd3; end
        3'd2: begin m = AM_IMM; c = 3'd2; end
        3'd3: begin m = AM_ABS; c = 3'd4; end
        3'd4: begin m = AM_INY; c = 3'd5; end
        3'd5: begin m = AM_ZPX; c = 3'd4; end
        3'd6: begin m = AM_ABY; c = 3'd4; end
        default: begin m = AM_ABX; c = 3'd4; end
      endcase
      k = kind_t'({2'b00, op[7:5]});
      // stores: no immediate; the (zp),y and absolute indexed forms take the longer count
      if (op[7:5] == 3'd4) begin
        if (op[4:2] == 3'd2) k = K_NONE;
        if (op[4:2] == 3'd4) c = 3'd6;
        if (op[4:2] >= 3'd6) c = 3'd5;
      end
    end else begin
      case (op)
        8'ha2: begin k = K_LDX; m = AM_IMM; end
        8'ha6: begin k = K_LDX; m = AM_ZP;  c = 3'd3; end
        8'hb6: begin k = K_LDX; m = AM_ZPY; c = 3'd4; end
        8'hae: begin k = K_LDX; m = AM_ABS; c = 3'd4; end
        8'hbe: begin k = K_LDX; m = AM_ABY; c = 3'd4; end
        8'ha0: begin k = K_LDY; m = AM_IMM; end
        8'ha4: begin k = K_LDY; m = AM_ZP;  c = 3'd3; end
        8'hb4: begin k = K_LDY; m = AM_ZPX; c = 3'd4; end
        8'hac: begin k = K_LDY; m = AM_ABS; c = 3'd4; end
        8'hbc: begin k = K_LDY; m = AM_ABX; c = 3'd4; end
        8'h86: begin k = K_STX; m = AM_ZP;  c = 3'd3; end
        8'h96: begin k = K_STX; m = AM_ZPY; c = 3'd4; end
        8'h8e: begin k = K_STX; m = AM_ABS; c = 3'd4; end
        8'h84: begin k = K_STY; m = AM_ZP;  c = 3'd3; end
        8'h94: begin k = K_STY; m = AM_ZPX; c = 3'd4; end
        8'h8c: begin k = K_STY; m = AM_ABS; c = 3'd4; end
        8'he0: begin k = K_CPX; m = AM_IMM; end
        8'he4: begin k = K_CPX; m = AM_ZP;  c = 3'd3; end
        8'hec: begin k = K_CPX; m = AM_ABS; c = 3'd4; end
        8'hc0: begin k = K_CPY; m = AM_IMM; end
        8'hc4: begin k = K_CPY; m = AM_ZP;  c = 3'd3; end
        8'hcc: begin k = K_CPY; m = AM_ABS; c = 3'd4; end
        8'h24: begin k = K_BIT; m = AM_ZP;  c = 3'd3; end
        8'h2c: begin k = K_BIT; m = AM_ABS; c = 3'd4; end
        8'haa: k = K_TAX;
        8'ha8: k = K_TAY;
        8'h8a: k = K_TXA;
        8'h98: k = K_TYA;
        8'hba: k = K_TSX;
        8'h9a: k = K_TXS;
        8'h48: begin k = K_PHA; c = 3'd3; end
        8'h08: begin k = K_PHP; c = 3'd3; end
        8'h68: begin k = K_PLA; c = 3'd4; end
        8'h28: begin k = K_PLP; c = 3'd4; end
        default: k = K_NONE;
      endcase
    end
  endfunction

  function automatic void upd_nz(input logic [7:0] v);
    r_p = (r_p & ~(FL_N | FL_Z)) | ((v == 8'h00) ? FL_Z : 8'h00) | (v & FL_N);
  endfunction

  function automatic void cmp_reg(input logic [7:0] r, input logic [7:0] v);
    upd_nz(r - v);
    r_p = (r_p & ~FL_C) | ((r >= v) ? FL_C : 8'h00);
  endfunction

  function automatic void add_with_carry(input logic [7:0] v);
    logic [8:0] sum;
    sum = {1'b0, r_a} + {1'b0, v} + {8'h00, r_p[0]};
    r_p = r_p & ~(FL_C | FL_V);
    if (sum[8]) r_p = r_p | FL_C;
    if ((~(r_a ^ v) & (r_a ^ sum[7:0]) & 8'h80) != 8'h00) r_p = r_p | FL_V;
    r_a = sum[7:0];
    upd_nz(r_a);
  endfunction

  // run one instruction at pc on the shadow state; returns cycles, flags bad opcode
  function automatic void step_cpu(output logic [2:0] cyc, output logic bad);
    kind_t       k;
    amode_t      m;
    logic [7:0]  lo, hi, zp, v;
    logic [15:0] ea, nxt;
    op_info(mem[r_pc], k, m, cyc);
    bad = (k == K_NONE);
    if (bad) begin
      cyc = 3'd0;
      return;
    end
    lo = mem[r_pc + 16'd1];
    hi = mem[r_pc + 16'd2];
    ea = 16'h0000;
    nxt = r_pc + 16'd2;
    case (m)
      AM_IMP: nxt = r_pc + 16'd1;
      AM_IMM: ea = r_pc + 16'd1;
      AM_ZP:  ea = {8'h00, lo};
      AM_ZPX: ea = {8'h00, lo + r_x};
      AM_ZPY: ea = {8'h00, lo + r_y};
      AM_ABS: begin ea = {hi, lo}; nxt = r_pc + 16'd3; end
      AM_ABX: begin ea = {hi, lo} + {8'h00, r_x}; nxt = r_pc + 16'd3; end
      AM_ABY: begin ea = {hi, lo} + {8'h00, r_y}; nxt = r_pc + 16'd3; end
      // pointers stay within page zero
      AM_INX: begin
        zp = lo + r_x;
        ea = {mem[{8'h00, zp + 8'd1}], mem[{8'h00, zp}]};
      end
      AM_INY: ea = {mem[{8'h00, lo + 8'd1}], mem[{8'h00, lo}]} + {8'h00, r_y};
      default: ea = 16'h0000;
    endcase
    v = (m == AM_IMP) ? 8'h00 : mem[ea];
    case (k)
      K_ORA: begin r_a = r_a | v; upd_nz(r_a); end
      K_AND: begin r_a = r_a & v; upd_nz(r_a); end
      K_EOR: begin r_a = r_a ^ v; upd_nz(r_a); end
      K_ADC: add_with_carry(v);
      K_SBC: add_with_carry(~v);
      K_STA: mem[ea] = r_a;
      K_STX: mem[ea] = r_x;
      K_STY: mem[ea] = r_y;
      K_LDA: begin r_a = v; upd_nz(v); end
      K_LDX: begin r_x = v; upd_nz(v); end
      K_LDY: begin r_y = v; upd_nz(v); end
      K_CMP: cmp_reg(r_a, v);
      K_CPX: cmp_reg(r_x, v);
      K_CPY: cmp_reg(r_y, v);
      K_BIT: begin
        r_p = (r_p & ~(FL_N | FL_V | FL_Z)) | (v & (FL_N | FL_V));
        if ((r_a & v) == 8'h00) r_p = r_p | FL_Z;
      end
      K_TAX: begin r_x = r_a; upd_nz(r_x); end
      K_TAY: begin r_y = r_a; upd_nz(r_y); end
      K_TXA: begin r_a = r_x; upd_nz(r_a); end
      K_TYA: begin r_a = r_y; upd_nz(r_a); end
      K_TSX: begin r_x = r_s; upd_nz(r_x); end
      K_TXS: r_s = r_x;
      K_PHA: begin mem[{8'h01, r_s}] = r_a; r_s = r_s - 8'd1; end
      K_PHP: begin mem[{8'h01, r_s}] = r_p | FL_B | FL_R; r_s = r_s - 8'd1; end
      K_PLA: begin r_s = r_s + 8'd1; r_a = mem[{8'h01, r_s}]; upd_nz(r_a); end
      K_PLP: begin r_s = r_s + 8'd1; r_p = (mem[{8'h01, r_s}] & ~FL_B) | FL_R; end
      default: ;
    endcase
    r_pc = nxt;
  endfunction

  function automatic cpu_view_t predict_word(input logic [1:0] act, input logic [15:0] ad,
                                             input logic [7:0] wb);
    cpu_view_t e;
    e.rd = 8'h00;
    e.cyc = 3'd0;
    e.bad = 1'b0;
    case (act)
      ACT_EXEC:  step_cpu(e.cyc, e.bad);
      ACT_WRITE: mem[ad] = wb;
      ACT_READ:  e.rd = mem[ad];
      default: ;
    endcase
    e.acc = r_a;
    e.xr = r_x;
    e.yr = r_y;
    e.flags = r_p | FL_R;
    e.sp = r_s;
    e.pc = r_pc;
    if (act == ACT_EXEC) n_exec++;
    if (e.bad) n_bad++;
    return e;
  endfunction

  function automatic int draw_gap(input bit fast);
    return fast ? 0 : int'($urandom_range(0, MAX_GAP));
  endfunction

  // drive one word at the falling edge and hold it until accepted
  task automatic send_word(input logic [1:0] act, input logic [15:0] ad, input logic [7:0] wb,
                           input bit typed, input dir_row_t row);
    int        gap;
    cpu_view_t e;
    gap = draw_gap(snd_fast);
    if (n_sent % 60 == 0) snd_fast = ($urandom_range(0, 3) == 0);
    e = predict_word(act, ad, wb);
    if (typed) begin
      e.pc = row.pc;
      e.rd = row.rd;
      e.cyc = row.cyc;
      e.bad = row.bad;
    end
    pending_q.push_back(e);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, wb, ad, act};
    do @(posedge clk); while (!s_tready);
    n_sent++;
  endtask

  // result side: random stalls, then compare against the oldest prediction
  initial begin : result_side
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = draw_gap(rcv_fast);
      if (n_got % 50 == 0) rcv_fast = ($urandom_range(0, 3) == 0);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      check_word(m_tdata);
      n_got++;
      @(negedge clk);
    end
  end

  task automatic field_cmp(input string nm, input logic [15:0] e, input logic [15:0] a);
    if (e !== a) begin
      n_err++;
      if (n_err <= 10)
        $display("mismatch word %0d %s: expected %0h got %0h", n_got, nm, e, a);
    end
  endtask

  task automatic check_word(input logic [71:0] d);
    cpu_view_t e;
    if (pending_q.size() == 0) begin
      n_err++;
      if (n_err <= 10) $display("unexpected word %0h", d);
      return;
    end
    e = pending_q.pop_front();
    field_cmp("accumulator", 16'(e.acc), 16'(d[7:0]));
    field_cmp("index_x", 16'(e.xr), 16'(d[15:8]));
    field_cmp("index_y", 16'(e.yr), 16'(d[23:16]));
    field_cmp("status_flags", 16'(e.flags), 16'(d[31:24]));
    field_cmp("stack_pointer", 16'(e.sp), 16'(d[39:32]));
    field_cmp("program_counter", e.pc, d[55:40]);
    field_cmp("read_byte", 16'(e.rd), 16'(d[63:56]));
    field_cmp("cycles_used", 16'(e.cyc), 16'(d[66:64]));
    field_cmp("bad_opcode", 16'(e.bad), 16'(d[67]));
  endtask

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYC_LIMIT) begin
      $display("timeout with %0d words outstanding", pending_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // stimulus
  initial begin : stim
    dir_row_t    rows [$];
    dir_row_t    nul;
    kind_t       k;
    amode_t      m;
    logic [2:0]  c;
    logic [7:0]  op;
    bit          paused;
    for (int i = 0; i < 65536; i++) mem[i] = 8'h00;
    r_a = 8'h00; r_x = 8'h00; r_y = 8'h00; r_s = 8'h00; r_p = FL_R; r_pc = 16'h0000;
    for (int i = 0; i < 256; i++) begin
      op_info(i[7:0], k, m, c);
      if (k != K_NONE) legal_ops.push_back(i[7:0]);
    end
    nul = '{ACT_EXEC, 16'h0, 8'h0, 0, 16'h0, 8'h0, 3'd0, 1'b0};
    // read after reset, unhandled opcode, unused action code, address extremes, then a short program
    rows = '{
      '{ACT_READ,  16'h0000, 8'h00, 1, 16'h0000, 8'h00, 3'd0, 1'b0},
      '{ACT_EXEC,  16'h0000, 8'h00, 1, 16'h0000, 8'h00, 3'd0, 1'b1},
      '{2'd3,      16'hffff, 8'hff, 1, 16'h0000, 8'h00, 3'd0, 1'b0},
      '{ACT_WRITE, 16'hffff, 8'hff, 1, 16'h0000, 8'h00, 3'd0, 1'b0},
      '{ACT_READ,  16'hffff, 8'h00, 1, 16'h0000, 8'hff, 3'd0, 1'b0},
      '{ACT_WRITE, 16'h0000, 8'ha9, 0, 0, 0, 0, 0},
      '{ACT_WRITE, 16'h0001, 8'h80, 0, 0, 0, 0, 0},
      '{ACT_EXEC,  16'h0000, 8'h00, 1, 16'h0002, 8'h00, 3'd2, 1'b0},
      '{ACT_WRITE, 16'h0002, 8'h69, 0, 0, 0, 0, 0},
      '{ACT_WRITE, 16'h0003, 8'h80, 0, 0, 0, 0, 0},
      '{ACT_EXEC,  16'h0000, 8'h00, 1, 16'h0004, 8'h00, 3'd2, 1'b0},
      '{ACT_WRITE, 16'h0004, 8'h48, 0, 0, 0, 0, 0},
      '{ACT_EXEC,  16'h0000, 8'h00, 1, 16'h0005, 8'h00, 3'd3, 1'b0},
      '{ACT_WRITE, 16'h0005, 8'h28, 0, 0, 0, 0, 0},
      '{ACT_EXEC,  16'h0000, 8'h00, 1, 16'h0006, 8'h00, 3'd4, 1'b0},
      '{ACT_WRITE, 16'h0006, 8'ha1, 0, 0, 0, 0, 0},
      '{ACT_WRITE, 16'h0007, 8'hff, 0, 0, 0, 0, 0},
      '{ACT_EXEC,  16'h0000, 8'h00, 1, 16'h0008, 8'h00, 3'd6, 1'b0},
      '{ACT_WRITE, 16'h0008, 8'hf1, 0, 0, 0, 0, 0},
      '{ACT_WRITE, 16'h0009, 8'hff, 0, 0, 0, 0, 0},
      '{ACT_EXEC,  16'h0000, 8'h00, 1, 16'h000a, 8'h00, 3'd5, 1'b0},
      '{ACT_WRITE, 16'h000a, 8'h9d, 0, 0, 0, 0, 0},
      '{ACT_WRITE, 16'h000b, 8'hff, 0, 0, 0, 0, 0},
      '{ACT_WRITE, 16'h000c, 8'hff, 0, 0, 0, 0, 0},
      '{ACT_EXEC,  16'h0000, 8'h00, 1, 16'h000d, 8'h00, 3'd5, 1'b0}
    };
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (rows[i]) send_word(rows[i].act, rows[i].addr, rows[i].wb, rows[i].chk, rows[i]);

    // random programs: plant an opcode and operands at pc, some data, execute, read, unused action
    paused = 0;
    while (n_sent < N_ITEMS) begin
      op = ($urandom_range(0, 99) < 85) ? legal_ops[$urandom_range(0, legal_ops.size() - 1)]
                                        : 8'($urandom_range(0, 255));
      send_word(ACT_WRITE, r_pc, op, 0, nul);
      send_word(ACT_WRITE, r_pc + 16'd1, 8'($urandom_range(0, 255)), 0, nul);
      if ($urandom_range(0, 1))
        send_word(ACT_WRITE, r_pc + 16'd2, 8'($urandom_range(0, 255)), 0, nul);
      if ($urandom_range(0, 2) == 0)
        send_word(ACT_WRITE, {8'h00, 8'($urandom_range(0, 255))}, 8'($urandom_range(0, 255)),
                  0, nul);
      if ($urandom_range(0, 4) == 0)
        send_word(ACT_WRITE, {8'h01, r_s + 8'd1}, 8'($urandom_range(0, 255)), 0, nul);
      send_word(ACT_EXEC, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)), 0, nul);
      if ($urandom_range(0, 3) == 0)
        send_word(ACT_READ, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)), 0, nul);
      if ($urandom_range(0, 3) == 0)
        send_word(ACT_READ, {8'h01, r_s + 8'd1}, 8'h00, 0, nul);
      if ($urandom_range(0, 49) == 0)
        send_word(2'd3, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)), 0, nul);
      // let the pipe drain completely once
      if (!paused && n_sent > N_ITEMS / 2) begin
        paused = 1;
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (pending_q.size() == 0);
      end
    end
    @(negedge clk);
    s_tvalid <= 1'b0;

    wait (pending_q.size() == 0);
    repeat (40) @(posedge clk);
    $display("sent %0d words, %0d results; %0d instructions executed, %0d unhandled opcodes",
             n_sent, n_got, n_exec, n_bad);
    if (n_err == 0 && pending_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", n_err);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
